// ===== rtl/prl_pkg.sv =====
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types, codes and sizes of the per-source packet rate limiter.
// ----------------------------------------------------------------------------
package prl_pkg;

   localparam int ENTRIES   = 64;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int KEY_W     = 64;
   localparam int TIME_W    = 64;
   localparam int TOK_W     = 32;
   localparam int IDLE_W    = 40;
   localparam int USED_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 40;

   // item kinds
   localparam logic [2:0] KIND_V4    = 3'd0;
   localparam logic [2:0] KIND_V6    = 3'd1;
   localparam logic [2:0] KIND_OTHER = 3'd2;
   localparam logic [2:0] KIND_SWEEP = 3'd3;
   localparam logic [2:0] KIND_FLUSH = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COST    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE    = 2'd2;

   // reset values: 20 packets a second, bursts of 5, 1 s idle, in 100 ns units
   localparam logic [TOK_W-1:0]  COST_RESET    = 32'd500000;
   localparam logic [TOK_W-1:0]  CEILING_RESET = 32'd2500000;
   localparam logic [IDLE_W-1:0] IDLE_RESET    = 40'd10000000;

   typedef struct packed {
      logic [2:0]        kind;
      logic [KEY_W-1:0]  source_key;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic              allowed;
      logic              table_full;
      logic [USED_W-1:0] entries_used;
   } rsp_type;

   // item walking down the cell chain, collecting lookup results
   typedef struct packed {
      logic              is_sweep;
      logic              is_v6;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now;
      logic              found;
      logic [IDX_W-1:0]  hit_idx;
      logic [TOK_W-1:0]  hit_tokens;
      logic [TIME_W-1:0] hit_last;
      logic              free_ok;
      logic [IDX_W-1:0]  free_idx;
      logic [CNT_W-1:0]  freed;
   } tok_type;

   // slot write broadcast to all cells
   typedef struct packed {
      logic              en;
      logic              create;
      logic [IDX_W-1:0]  idx;
      logic              is_v6;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] last;
      logic [TOK_W-1:0]  tokens;
   } wr_type;

   // outcome of the refill and charge unit
   typedef struct packed {
      logic              done;
      logic              allowed;
      logic [TOK_W-1:0]  tokens;
   } refill_type;

endpackage

// ===== rtl/per_source_packet_rate_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// per_source_packet_rate_limiter_unit
// Token bucket per source key, held in a chain of slot cells.
//
//   channel  ports                         direction  contents
//   req      req_valid req_ready req_data  in         kind, source key, time
//   rsp      rsp_valid rsp_ready rsp_data  out        allowed, full, used count
//   csr      csr_valid csr_ready csr_index in         cost, ceiling, idle limit
//            csr_data
//
// A packet or sweep walks the ENTRIES cells one per cycle; a packet that
// finds a known bucket then passes the refill unit. Flush and other kinds
// skip the walk. One item is in work at a time.
// Reset clears every slot at once; no clearing pass is needed.
// The result waits in an output register; a stalled rsp holds only the
// finishing step, a new item is taken while a result waits.
// ----------------------------------------------------------------------------
module per_source_packet_rate_limiter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  prl_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output prl_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [prl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [prl_pkg::CSR_DAT_W-1:0]    csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_CALC = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [prl_pkg::TOK_W-1:0]       cost_ff, ceiling_ff;
   logic [prl_pkg::IDLE_W-1:0]      idle_ff;
   logic [prl_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            tok0_vld_ff, tok0_vld_in;
   prl_pkg::tok_type                tok0_ff, tok0_in;
   prl_pkg::tok_type                hold_ff;
   logic                            res_allowed_ff, res_allowed_in;
   logic                            res_full_ff, res_full_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   prl_pkg::rsp_type                rsp_ff;
   logic                            req_fire, flush, rsp_load;
   prl_pkg::wr_type                 wr;
   prl_pkg::refill_type             rf;
   logic                            rf_start;
   logic [prl_pkg::TOK_W:0]         start_diff;
   logic [prl_pkg::TOK_W-1:0]       start_tokens;
   logic [prl_pkg::CNT_W+prl_pkg::USED_W-1:0] used_wide;

   prl_pkg::tok_type                chain_tok [prl_pkg::ENTRIES+1];
   logic [prl_pkg::ENTRIES:0]       chain_vld;
   prl_pkg::tok_type                end_tok;
   logic                            end_vld;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign flush     = req_fire && (req_data.kind == prl_pkg::KIND_FLUSH);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign chain_tok[0] = tok0_ff;
   assign chain_vld[0] = tok0_vld_ff;
   assign end_tok      = chain_tok[prl_pkg::ENTRIES];
   assign end_vld      = chain_vld[prl_pkg::ENTRIES];

   for (genvar g = 0; g < prl_pkg::ENTRIES; g++) begin : g_cell
      prl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (prl_pkg::IDX_W'(g)),
         .idle_limit (idle_ff),
         .flush      (flush),
         .wr         (wr),
         .in_vld     (chain_vld[g]),
         .in_tok     (chain_tok[g]),
         .out_vld    (chain_vld[g+1]),
         .out_tok    (chain_tok[g+1])
      );
   end

   assign rf_start = (state_ff == S_WALK) && end_vld && !end_tok.is_sweep && end_tok.found;

   prl_refill u_refill (
      .clock   (clock),
      .reset   (reset),
      .start   (rf_start),
      .tokens  (end_tok.hit_tokens),
      .last    (end_tok.hit_last),
      .now     (end_tok.now),
      .ceiling (ceiling_ff),
      .cost    (cost_ff),
      .result  (rf)
   );

   // a new bucket starts one cost below the ceiling, never below zero
   assign start_diff   = {1'b0, ceiling_ff} - {1'b0, cost_ff};
   assign start_tokens = start_diff[prl_pkg::TOK_W] ? '0 : start_diff[prl_pkg::TOK_W-1:0];

   always_comb begin
      tok0_in          = '0;
      tok0_in.is_sweep = (req_data.kind == prl_pkg::KIND_SWEEP);
      tok0_in.is_v6    = (req_data.kind == prl_pkg::KIND_V6);
      tok0_in.key      = req_data.source_key;
      tok0_in.now      = req_data.now_time;
      if (req_data.kind == prl_pkg::KIND_V4) begin
         tok0_in.key[prl_pkg::KEY_W-1:32] = '0;
      end
      tok0_vld_in = 1'b0;

      wr             = '0;
      state_in       = state_ff;
      count_in       = count_ff;
      res_allowed_in = res_allowed_ff;
      res_full_in    = res_full_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_allowed_in = 1'b0;
               res_full_in    = 1'b0;
               unique case (req_data.kind)
                  prl_pkg::KIND_V4, prl_pkg::KIND_V6, prl_pkg::KIND_SWEEP: begin
                     tok0_vld_in = 1'b1;
                     state_in    = S_WALK;
                  end
                  prl_pkg::KIND_FLUSH: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (end_vld) begin
               priority if (end_tok.is_sweep) begin
                  count_in = count_ff - end_tok.freed;
                  state_in = S_DONE;
               end else if (end_tok.found) begin
                  state_in = S_CALC;
               end else if (end_tok.free_ok) begin
                  wr.en          = 1'b1;
                  wr.create      = 1'b1;
                  wr.idx         = end_tok.free_idx;
                  wr.is_v6       = end_tok.is_v6;
                  wr.key         = end_tok.key;
                  wr.last        = end_tok.now;
                  wr.tokens      = start_tokens;
                  count_in       = count_ff + 1'b1;
                  res_allowed_in = 1'b1;
                  state_in       = S_DONE;
               end else begin
                  res_full_in = 1'b1;
                  state_in    = S_DONE;
               end
            end
         end
         S_CALC: begin
            if (rf.done) begin
               wr.en          = 1'b1;
               wr.idx         = hold_ff.hit_idx;
               wr.last        = hold_ff.now;
               wr.tokens      = rf.tokens;
               res_allowed_in = rf.allowed;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   assign used_wide = {{prl_pkg::USED_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         tok0_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         res_allowed_ff <= 1'b0;
         res_full_ff    <= 1'b0;
         cost_ff        <= prl_pkg::COST_RESET;
         ceiling_ff     <= prl_pkg::CEILING_RESET;
         idle_ff        <= prl_pkg::IDLE_RESET;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         tok0_vld_ff    <= tok0_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         res_allowed_ff <= res_allowed_in;
         res_full_ff    <= res_full_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               prl_pkg::CSR_COST:    cost_ff    <= csr_data[prl_pkg::TOK_W-1:0];
               prl_pkg::CSR_CEILING: ceiling_ff <= csr_data[prl_pkg::TOK_W-1:0];
               prl_pkg::CSR_IDLE:    idle_ff    <= csr_data[prl_pkg::IDLE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tok0_ff <= tok0_in;
      if (state_ff == S_WALK && end_vld) begin
         hold_ff <= end_tok;
      end
      if (rsp_load) begin
         rsp_ff.allowed      <= res_allowed_ff;
         rsp_ff.table_full   <= res_full_ff;
         rsp_ff.entries_used <= used_wide[prl_pkg::USED_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the walking item only reaches the chain end while the walk is awaited
   a_end_in_walk: assert property (@(posedge clock) disable iff (reset)
      end_vld |-> state_ff == S_WALK)
      else $error("item left the cell chain outside the walk");

   a_refill_in_calc: assert property (@(posedge clock) disable iff (reset)
      rf.done |-> state_ff == S_CALC)
      else $error("refill finished outside the calc step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= prl_pkg::CNT_W'(prl_pkg::ENTRIES))
      else $error("slot count above table size");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      flush |=> count_ff == '0)
      else $error("flush left slots counted");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == S_WALK || state_ff == S_CALC) && !tok0_vld_ff)
      else $error("slot write while an item is entering the chain");

endmodule

// ===== rtl/prl_cell.sv =====
// ----------------------------------------------------------------------------
// prl_cell
// One bucket slot of the chain: compares the passing item with its key,
// ages itself on a sweep and hands the item on to the next cell.
// ----------------------------------------------------------------------------
module prl_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [prl_pkg::IDX_W-1:0]       cell_index,
   input  logic [prl_pkg::IDLE_W-1:0]      idle_limit,
   input  logic                            flush,
   input  prl_pkg::wr_type                 wr,
   input  logic                            in_vld,
   input  prl_pkg::tok_type                in_tok,
   output logic                            out_vld,
   output prl_pkg::tok_type                out_tok
);

   logic                            valid_ff, valid_in;
   logic                            is_v6_ff;
   logic [prl_pkg::KEY_W-1:0]       key_ff;
   logic [prl_pkg::TIME_W-1:0]      last_ff;
   logic [prl_pkg::TOK_W-1:0]       tokens_ff;
   logic                            out_vld_ff;
   prl_pkg::tok_type                out_tok_ff, out_tok_in;
   logic                            match, stale, wr_hit;
   logic [prl_pkg::TIME_W-1:0]      elapsed;

   always_comb begin
      match   = valid_ff && !in_tok.is_sweep && (is_v6_ff == in_tok.is_v6)
                && (key_ff == in_tok.key);
      elapsed = in_tok.now - last_ff;
      stale   = in_vld && valid_ff && in_tok.is_sweep
                && (elapsed > {{(prl_pkg::TIME_W-prl_pkg::IDLE_W){1'b0}}, idle_limit});
      wr_hit  = wr.en && (wr.idx == cell_index);

      out_tok_in = in_tok;
      // keys are unique, only the first hit counts
      if (match && !in_tok.found) begin
         out_tok_in.found      = 1'b1;
         out_tok_in.hit_idx    = cell_index;
         out_tok_in.hit_tokens = tokens_ff;
         out_tok_in.hit_last   = last_ff;
      end
      // lowest free slot wins
      if (!valid_ff && !in_tok.free_ok && !in_tok.is_sweep) begin
         out_tok_in.free_ok  = 1'b1;
         out_tok_in.free_idx = cell_index;
      end
      if (stale) begin
         out_tok_in.freed = in_tok.freed + 1'b1;
      end

      priority if (flush) begin
         valid_in = 1'b0;
      end else if (wr_hit && wr.create) begin
         valid_in = 1'b1;
      end else if (stale) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         out_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff <= out_tok_in;
      if (wr_hit) begin
         last_ff   <= wr.last;
         tokens_ff <= wr.tokens;
         if (wr.create) begin
            is_v6_ff <= wr.is_v6;
            key_ff   <= wr.key;
         end
      end
   end

   assign out_vld = out_vld_ff;
   assign out_tok = out_tok_ff;

endmodule

// ===== rtl/prl_refill.sv =====
// ----------------------------------------------------------------------------
// prl_refill
// Two-stage refill and charge of a hit bucket: add elapsed time up to the
// ceiling, then take one packet's cost if the balance covers it.
// ----------------------------------------------------------------------------
module prl_refill (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [prl_pkg::TOK_W-1:0]   tokens,
   input  logic [prl_pkg::TIME_W-1:0]  last,
   input  logic [prl_pkg::TIME_W-1:0]  now,
   input  logic [prl_pkg::TOK_W-1:0]   ceiling,
   input  logic [prl_pkg::TOK_W-1:0]   cost,
   output prl_pkg::refill_type         result
);

   logic                        s1_vld_ff;
   logic                        sat_ff, sat_in;
   logic [prl_pkg::TOK_W-1:0]   sum_ff, sum_in;
   logic                        done_ff;
   logic                        allowed_ff, allowed_in;
   logic [prl_pkg::TOK_W-1:0]   tok_ff, tok_in;
   logic [prl_pkg::TIME_W-1:0]  elapsed;
   logic [prl_pkg::TOK_W-1:0]   headroom;
   logic [prl_pkg::TOK_W-1:0]   filled;
   logic [prl_pkg::TOK_W:0]     diff;

   always_comb begin
      elapsed  = now - last;
      headroom = ceiling - tokens;
      // a balance above a lowered ceiling clamps to it
      sat_in   = (tokens >= ceiling)
                 || (elapsed >= {{(prl_pkg::TIME_W-prl_pkg::TOK_W){1'b0}}, headroom});
      sum_in   = tokens + elapsed[prl_pkg::TOK_W-1:0];

      filled     = sat_ff ? ceiling : sum_ff;
      diff       = {1'b0, filled} - {1'b0, cost};
      allowed_in = !diff[prl_pkg::TOK_W];
      tok_in     = allowed_in ? diff[prl_pkg::TOK_W-1:0] : filled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= start;
         done_ff   <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff     <= sat_in;
      sum_ff     <= sum_in;
      allowed_ff <= allowed_in;
      tok_ff     <= tok_in;
   end

   assign result.done    = done_ff;
   assign result.allowed = allowed_ff;
   assign result.tokens  = tok_ff;

endmodule
